// ===== hdl/wcpr_pkg.sv =====
// Shared types and constants of the waveform column peak reducer.
`timescale 1ns / 1ps

package wcpr_pkg;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic CFG_FRAMES_PER_COLUMN = 1'b0;
	localparam logic CFG_NUM_FRAMES        = 1'b1;

	localparam logic [31:0] FPC_RESET        = 32'h0001_0000;
	localparam logic [12:0] NUM_FRAMES_RESET = 13'd0;

	typedef struct packed {
		logic [7:0] left_low;
		logic [7:0] left_mid;
		logic [7:0] left_high;
		logic [7:0] right_low;
		logic [7:0] right_mid;
		logic [7:0] right_high;
	} frame_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	function automatic logic [7:0] level_max(logic [7:0] a, logic [7:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic frame_t frame_max(frame_t a, frame_t b);
		frame_t r;
		r.left_low   = level_max(a.left_low,   b.left_low);
		r.left_mid   = level_max(a.left_mid,   b.left_mid);
		r.left_high  = level_max(a.left_high,  b.left_high);
		r.right_low  = level_max(a.right_low,  b.right_low);
		r.right_mid  = level_max(a.right_mid,  b.right_mid);
		r.right_high = level_max(a.right_high, b.right_high);
		return r;
	endfunction

endpackage

// ===== hdl/wcpr_if.sv =====
// Channel interfaces of the waveform column peak reducer.
`timescale 1ns / 1ps

interface wcpr_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [11:0] frame_index;
	logic [7:0]  left_low;
	logic [7:0]  left_mid;
	logic [7:0]  left_high;
	logic [7:0]  right_low;
	logic [7:0]  right_mid;
	logic [7:0]  right_high;
	logic [15:0] column;

	modport source (
		output valid, cmd, frame_index, left_low, left_mid, left_high,
		       right_low, right_mid, right_high, column,
		input  ready
	);
	modport sink (
		input  valid, cmd, frame_index, left_low, left_mid, left_high,
		       right_low, right_mid, right_high, column,
		output ready
	);
endinterface

interface wcpr_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] column_out;
	logic [7:0]  left_low_peak;
	logic [7:0]  left_mid_peak;
	logic [7:0]  left_high_peak;
	logic [7:0]  right_low_peak;
	logic [7:0]  right_mid_peak;
	logic [7:0]  right_high_peak;

	modport source (
		output valid, column_out, left_low_peak, left_mid_peak, left_high_peak,
		       right_low_peak, right_mid_peak, right_high_peak,
		input  ready
	);
	modport sink (
		input  valid, column_out, left_low_peak, left_mid_peak, left_high_peak,
		       right_low_peak, right_mid_peak, right_high_peak,
		output ready
	);
endinterface

interface wcpr_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/wcpr_span.sv =====
// Window bounds of a query: Q16.16 centre, rounded ends, clamping.
`timescale 1ns / 1ps

module wcpr_span #(
	parameter int FRAME_DEPTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [15:0]                          column,
	input  logic [31:0]                          frames_per_column,
	input  logic [$clog2(FRAME_DEPTH+1)-1:0]     frame_count,
	output logic                                 done,
	output logic                                 nonempty,
	output logic [$clog2(FRAME_DEPTH)-1:0]       first,
	output logic [$clog2(FRAME_DEPTH)-1:0]       last
);

	localparam int AW = $clog2(FRAME_DEPTH);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [47:0] prod_s1;
	logic [31:0] fpc_s1;
	logic [50:0] ts_s2;
	logic [49:0] te_s2;
	logic [32:0] first_s3, stop_s3;
	logic        nonempty_s4;
	logic [AW-1:0] first_s4, last_s4;

	logic        s_neg;
	logic [32:0] s_first, s_end, s_stop;
	logic [32:0] n33, stop_c, stop_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// rounding offset of half a frame folded into both ends
	always_comb begin
		s_neg   = ts_s2[50] | (ts_s2 == '0);
		s_first = s_neg ? '0 : ts_s2[49:17];
		s_end   = te_s2[49:17];
		if (s_neg) begin
			s_stop = s_end;
		end else begin
			s_stop = (s_end > s_first) ? s_end : s_first + 33'd1;
		end
		n33     = 33'(frame_count);
		stop_c  = (stop_s3 > n33) ? n33 : stop_s3;
		stop_m1 = stop_c - 33'd1;
	end

	always_ff @(posedge clk) begin
		prod_s1     <= column * frames_per_column;
		fpc_s1      <= frames_per_column;
		ts_s2       <= {2'b00, prod_s1, 1'b0} - {19'd0, fpc_s1} + 51'd65536;
		te_s2       <= {1'b0, prod_s1, 1'b0} + {18'd0, fpc_s1} + 50'd65536;
		first_s3    <= s_first;
		stop_s3     <= s_stop;
		nonempty_s4 <= first_s3 < stop_c;
		first_s4    <= first_s3[AW-1:0];
		last_s4     <= stop_m1[AW-1:0];
	end

	assign done     = v_s4;
	assign nonempty = nonempty_s4;
	assign first    = first_s4;
	assign last     = last_s4;

endmodule

// ===== hdl/waveform_column_peak_reducer.sv =====
// Top level: frame store, window scan and result register.
//
//  channel   role    handshake     carries
//  item      sink    valid/ready   cmd, frame_index, six levels, column
//  result    source  valid/ready   column_out, six peaks
//  cfg       sink    valid/ready   index, data (ready always high)
//
// A write is taken only while idle. A query holds the input from its transfer until
// its result is loaded: the bound arithmetic, then one frame a cycle through the single
// read port of the store over the frames of its window, then the drain and the done
// state. An empty window skips the scan and the drain.
// Reset clears control, configuration and valid flags; data registers and the store are not reset.
// A waiting result stalls a finished query in its last cycle until the transfer.
`timescale 1ns / 1ps

module waveform_column_peak_reducer #(
	parameter int FRAME_DEPTH = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	wcpr_item_if.sink            item,
	wcpr_result_if.source        result,
	wcpr_cfg_if.sink             cfg
);

	localparam int AW = $clog2(FRAME_DEPTH);
	localparam int CW = $clog2(FRAME_DEPTH + 1);
	localparam logic [31:0] DEPTH32 = 32'(FRAME_DEPTH);

	wcpr_pkg::state_t state_q, state_d;

	logic [31:0] fpc_q;
	logic [12:0] num_frames_q;

	wcpr_pkg::frame_t mem [FRAME_DEPTH];
	wcpr_pkg::frame_t rdata_s1;
	wcpr_pkg::frame_t wr_frame;
	wcpr_pkg::frame_t peak_q;
	wcpr_pkg::frame_t out_q;

	logic          item_xfer, query_xfer, wr_en, rd_en, rvalid_s1;
	logic [31:0]   idx32, n32;
	logic [CW-1:0] frame_count;
	logic [AW-1:0] rd_addr_q, last_q;
	logic [15:0]   col_q, out_col_q;
	logic          out_valid_q, out_load;

	logic          span_done, span_nonempty;
	logic [AW-1:0] span_first, span_last;

	assign item_xfer  = item.valid & item.ready;
	assign query_xfer = item_xfer & (item.cmd == wcpr_pkg::CMD_QUERY);
	assign idx32      = 32'(item.frame_index);
	assign wr_en      = item_xfer & (item.cmd == wcpr_pkg::CMD_WRITE) & (idx32 < DEPTH32);
	assign n32        = (32'(num_frames_q) > DEPTH32) ? DEPTH32 : 32'(num_frames_q);
	assign frame_count = n32[CW-1:0];

	assign wr_frame = '{
		left_low:   item.left_low,
		left_mid:   item.left_mid,
		left_high:  item.left_high,
		right_low:  item.right_low,
		right_mid:  item.right_mid,
		right_high: item.right_high
	};

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpc_q        <= wcpr_pkg::FPC_RESET;
			num_frames_q <= wcpr_pkg::NUM_FRAMES_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				wcpr_pkg::CFG_FRAMES_PER_COLUMN: fpc_q        <= cfg.data;
				wcpr_pkg::CFG_NUM_FRAMES:        num_frames_q <= cfg.data[12:0];
				default: ;
			endcase
		end
	end

	wcpr_span #(
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_span (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (query_xfer),
		.column            (item.column),
		.frames_per_column (fpc_q),
		.frame_count       (frame_count),
		.done              (span_done),
		.nonempty          (span_nonempty),
		.first             (span_first),
		.last              (span_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcpr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		rd_en      = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			wcpr_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid && item.cmd == wcpr_pkg::CMD_QUERY) begin
					state_d = wcpr_pkg::ST_SPAN;
				end
			end
			wcpr_pkg::ST_SPAN: begin
				if (span_done) begin
					state_d = span_nonempty ? wcpr_pkg::ST_SCAN : wcpr_pkg::ST_DONE;
				end
			end
			wcpr_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (rd_addr_q == last_q) begin
					state_d = wcpr_pkg::ST_DRAIN;
				end
			end
			wcpr_pkg::ST_DRAIN: begin
				state_d = wcpr_pkg::ST_DONE;
			end
			wcpr_pkg::ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = wcpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wcpr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx32[AW-1:0]] <= wr_frame;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_xfer) begin
			col_q  <= item.column;
			peak_q <= '0;
		end else if (rvalid_s1) begin
			peak_q <= wcpr_pkg::frame_max(peak_q, rdata_s1);
		end
		if (span_done) begin
			rd_addr_q <= span_first;
			last_q    <= span_last;
		end else if (rd_en) begin
			rd_addr_q <= rd_addr_q + AW'(1);
		end
		if (out_load) begin
			out_q     <= peak_q;
			out_col_q <= col_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.column_out      = out_col_q;
	assign result.left_low_peak   = out_q.left_low;
	assign result.left_mid_peak   = out_q.left_mid;
	assign result.left_high_peak  = out_q.left_high;
	assign result.right_low_peak  = out_q.right_low;
	assign result.right_mid_peak  = out_q.right_mid;
	assign result.right_high_peak = out_q.right_high;

endmodule

// ===== hdl/wcpr_checker.sv =====
// Port-level checks of the waveform column peak reducer and their binding.
`timescale 1ns / 1ps

module wcpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        item_cmd,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] result_column_out
);

	logic [1:0] pending_q;
	logic       query_xfer, result_xfer;

	assign query_xfer  = item_valid & item_ready & (item_cmd == wcpr_pkg::CMD_QUERY);
	assign result_xfer = result_valid & result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (query_xfer && !result_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (result_xfer && !query_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 2'd0)
		else $error("result shown with no query outstanding");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two queries outstanding");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd2 |-> !item_ready)
		else $error("item taken while a query computes and a result waits");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_column_out))
		else $error("stalled result changed");

endmodule

bind waveform_column_peak_reducer wcpr_checker u_wcpr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_cmd          (item.cmd),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_column_out (result.column_out)
);
